/* design/tcp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_pkg: shared types and constants of the timestamp chunk placer
// Item layouts, configuration layout, result kinds and divider interface.
// ----------------------------------------------------------------------------
package tcp_pkg;

    localparam int STAMP_BITS = 48;
    localparam int BASE_W     = 64;   // internal base and offset arithmetic
    localparam int LEN_W      = 20;
    localparam int SPP_W      = 17;
    localparam int SPC_W      = 27;
    localparam int BPS_W      = 5;
    localparam int SLOT_W     = 23;
    localparam int OFF_W      = 27;
    localparam int CNT_W      = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;
    localparam logic [CFG_IDX_W-1:0] CFG_SPP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BPS = 2'd2;

    localparam logic [SPP_W-1:0] SPP_RESET = 17'd4096;
    localparam logic [SPC_W-1:0] SPC_RESET = 27'd1048576;
    localparam logic [BPS_W-1:0] BPS_RESET = 5'd10;

    localparam int DIV_W          = BASE_W;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_ITERS      = DIV_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_ITERS);

    typedef enum logic [2:0] {
        KIND_PLACED     = 3'd0,
        KIND_FLUSH      = 3'd1,
        KIND_INVALID    = 3'd2,
        KIND_WRONG_SIZE = 3'd3,
        KIND_MISALIGNED = 3'd4,
        KIND_TOO_OLD    = 3'd5
    } t_kind;

    typedef struct packed {
        logic                  has_stamp;
        logic [STAMP_BITS-1:0] stamp;
        logic [LEN_W-1:0]      payload_bytes;
    } t_in_item;

    typedef struct packed {
        t_kind                 kind;
        logic [STAMP_BITS-1:0] chunk_base;
        logic [SLOT_W-1:0]     packet_slot;
        logic [OFF_W-1:0]      byte_offset;
        logic                  final_result;
    } t_out_item;

    typedef struct packed {
        logic [SPP_W-1:0] spp;
        logic [SPC_W-1:0] spc;
        logic [BPS_W-1:0] bps;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [SPC_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [SPC_W-1:0] remainder;
    } t_div_rsp;

endpackage

/* design/timestamp_chunk_placer.sv */
`timescale 1ns / 1ps
// A placed item lands in a chunk of the window, moves the window on by one chunk, opens
// it as the first item, or skips ahead; the later cases add divisions or flushes.
// Invalid and wrong-size drops leave from the check, misaligned ones after the alignment
// division, too-old ones after the window lookup. Throughput: one item at a time, the next
// accepted once the last result leaves the core; up to 3 shared divisions per item.
// Reset clears the window, restores default configuration and empties the output.
// ----------------------------------------------------------------------------
// timestamp_chunk_placer: places packet descriptors into a two-chunk window
// Configuration registers, sequencer core and shared divider.
// ----------------------------------------------------------------------------
module timestamp_chunk_placer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tcp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tcp_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tcp_pkg::t_out_item               o_out_data
);

    tcp_pkg::t_cfg     r_cfg;
    tcp_pkg::t_div_req div_req;
    tcp_pkg::t_div_rsp div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spp <= tcp_pkg::SPP_RESET;
            r_cfg.spc <= tcp_pkg::SPC_RESET;
            r_cfg.bps <= tcp_pkg::BPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcp_pkg::CFG_SPP: r_cfg.spp <= i_cfg_data[tcp_pkg::SPP_W-1:0];
                tcp_pkg::CFG_SPC: r_cfg.spc <= i_cfg_data[tcp_pkg::SPC_W-1:0];
                tcp_pkg::CFG_BPS: r_cfg.bps <= i_cfg_data[tcp_pkg::BPS_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    tcp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    tcp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

/* design/tcp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_div: shared iterative divider
// Restoring division, two quotient bits per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module tcp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcp_pkg::t_div_req i_req,
    output tcp_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [tcp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [tcp_pkg::DIV_W-1:0]     r_q;
    logic [tcp_pkg::SPC_W-1:0]     r_rem;
    logic [tcp_pkg::SPC_W-1:0]     r_d;

    logic [tcp_pkg::DIV_W-1:0]     n_q;
    logic [tcp_pkg::SPC_W-1:0]     n_rem;

    // dividend bits shift out of the top of r_q while quotient bits enter below
    always_comb begin
        logic [tcp_pkg::SPC_W:0] trial;
        n_q   = r_q;
        n_rem = r_rem;
        for (int i = 0; i < tcp_pkg::DIV_RADIX_BITS; i++) begin
            trial = {n_rem, n_q[tcp_pkg::DIV_W-1]};
            n_q   = {n_q[tcp_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_d}) begin
                trial  = trial - {1'b0, r_d};
                n_q[0] = 1'b1;
            end
            n_rem = trial[tcp_pkg::SPC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_d    <= i_req.divisor;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tcp_pkg::DIV_CNT_W'(tcp_pkg::DIV_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("divider started while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while still busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without a run");

endmodule

/* design/tcp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_core: sequencer and window state of the chunk placer
// Checks one descriptor, drives the shared divider and emits result items.
// ----------------------------------------------------------------------------
module tcp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcp_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcp_pkg::t_out_item o_out_data,
    output tcp_pkg::t_div_req  o_div_req,
    input  tcp_pkg::t_div_rsp  i_div_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FIRST_WAIT,
        S_PREP,
        S_MOD_WAIT,
        S_LOC_OLD,
        S_LOC_NEW,
        S_JUMP,
        S_JUMP_WAIT,
        S_FLUSH,
        S_SLOT,
        S_SLOT_WAIT,
        S_EMIT
    } t_state;

    localparam int BW = tcp_pkg::BASE_W;
    localparam int SB = tcp_pkg::STAMP_BITS;

    t_state                         r_state, n_state;
    logic                           r_has, n_has;
    logic [SB-1:0]                  r_stamp, n_stamp;
    logic [tcp_pkg::LEN_W-1:0]      r_len, n_len;
    logic                           r_started, n_started;
    logic [SB-1:0]                  r_first, n_first;
    logic [tcp_pkg::CNT_W-1:0]      r_count, n_count;
    logic [BW-1:0]                  r_oldest, n_oldest;
    logic [BW-1:0]                  r_newest, n_newest;
    logic [BW-1:0]                  r_start, n_start;
    logic [BW-1:0]                  r_base, n_base;
    logic                           r_maxact, n_maxact;
    logic [tcp_pkg::OFF_W-1:0]      r_off, n_off;
    tcp_pkg::t_out_item             r_res, n_res;
    logic                           r_out_valid, n_out_valid;
    tcp_pkg::t_out_item             r_out, n_out;

    logic                           in_accept;
    logic                           out_free;
    logic [BW-1:0]                  stamp64;
    logic [tcp_pkg::SPC_W-1:0]      spc_eff;
    logic [BW-1:0]                  spc64;
    logic [SB-1:0]                  diff;
    logic [BW-1:0]                  sidx;
    logic [BW-1:0]                  old_end;
    logic [BW-1:0]                  new_end;
    logic [BW-1:0]                  jump_end;
    logic [tcp_pkg::OFF_W+tcp_pkg::BPS_W-1:0] off_prod;
    logic [tcp_pkg::LEN_W-1:0]      pkt_bytes;

    function automatic tcp_pkg::t_out_item drop_item(input tcp_pkg::t_kind kind);
        tcp_pkg::t_out_item it;
        it              = '0;
        it.kind         = kind;
        it.final_result = 1'b1;
        return it;
    endfunction

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign stamp64     = BW'(r_stamp);
    assign spc_eff     = (i_cfg.spc == '0) ? tcp_pkg::SPC_W'(i_cfg.spp) : i_cfg.spc;
    assign spc64       = BW'(spc_eff);
    assign pkt_bytes   = tcp_pkg::LEN_W'(i_cfg.spp[tcp_pkg::SPP_W-1:3] * i_cfg.bps);
    assign diff        = (r_stamp >= r_first) ? r_stamp - r_first : r_first - r_stamp;
    assign sidx        = stamp64 - r_base;   // wraps like the 64-bit datapath
    assign old_end     = r_oldest + spc64;
    assign new_end     = r_newest + spc64;
    assign jump_end    = r_start + spc64;
    assign off_prod    = sidx[tcp_pkg::OFF_W+2:3] * i_cfg.bps;

    // divider operands by issuing state
    always_comb begin
        o_div_req = '0;
        case (r_state)
            S_CHECK: begin
                o_div_req.dividend = stamp64;
                o_div_req.divisor  = spc_eff;
                o_div_req.start    = r_has && (r_len != '0) && (r_len == pkt_bytes)
                                     && (i_cfg.spp != '0) && !r_started;
            end
            S_PREP: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = BW'(diff);
                o_div_req.divisor  = tcp_pkg::SPC_W'(i_cfg.spp);
            end
            S_JUMP: begin
                o_div_req.start    = (stamp64 >= jump_end);
                o_div_req.dividend = stamp64 - r_start;
                o_div_req.divisor  = spc_eff;
            end
            S_SLOT: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = sidx;
                o_div_req.divisor  = tcp_pkg::SPC_W'(i_cfg.spp);
            end
            default: begin
                o_div_req = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_has       = r_has;
        n_stamp     = r_stamp;
        n_len       = r_len;
        n_started   = r_started;
        n_first     = r_first;
        n_count     = r_count;
        n_oldest    = r_oldest;
        n_newest    = r_newest;
        n_start     = r_start;
        n_base      = r_base;
        n_maxact    = r_maxact;
        n_off       = r_off;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_has   = i_in_data.has_stamp;
                    n_stamp = i_in_data.stamp;
                    n_len   = i_in_data.payload_bytes;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!r_has || r_len == '0) begin
                    n_res   = drop_item(tcp_pkg::KIND_INVALID);
                    n_state = S_EMIT;
                end else if (r_len != pkt_bytes || i_cfg.spp == '0) begin
                    n_res   = drop_item(tcp_pkg::KIND_WRONG_SIZE);
                    n_state = S_EMIT;
                end else if (!r_started) begin
                    n_state = S_FIRST_WAIT;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_FIRST_WAIT: begin
                if (i_div_rsp.done) begin
                    // stamp rounded down to a chunk boundary
                    n_first   = r_stamp - SB'(i_div_rsp.remainder);
                    n_started = 1'b1;
                    n_count   = 2'd1;
                    n_oldest  = BW'(r_stamp - SB'(i_div_rsp.remainder));
                    n_newest  = BW'(r_stamp - SB'(i_div_rsp.remainder));
                    n_state   = S_PREP;
                end
            end
            S_PREP: begin
                if (r_count == '0) begin
                    n_count  = 2'd1;
                    n_newest = r_oldest;
                end
                n_state = S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
                if (i_div_rsp.done) begin
                    if (i_div_rsp.remainder != '0) begin
                        n_res   = drop_item(tcp_pkg::KIND_MISALIGNED);
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_LOC_OLD;
                    end
                end
            end
            S_LOC_OLD: begin
                if (stamp64 >= r_oldest && stamp64 < old_end) begin
                    n_base  = r_oldest;
                    n_state = S_SLOT;
                end else begin
                    n_state = S_LOC_NEW;
                end
            end
            S_LOC_NEW: begin
                if (r_count >= 2'd2 && stamp64 >= r_newest && stamp64 < new_end) begin
                    n_base  = r_newest;
                    n_state = S_SLOT;
                end else if (stamp64 < r_oldest) begin
                    n_res   = drop_item(tcp_pkg::KIND_TOO_OLD);
                    n_state = S_EMIT;
                end else begin
                    n_start = new_end;
                    n_state = S_JUMP;
                end
            end
            S_JUMP: begin
                // a jump past the next chunk empties the window
                if (stamp64 >= jump_end) begin
                    n_maxact = 1'b0;
                    n_state  = S_JUMP_WAIT;
                end else begin
                    n_maxact = 1'b1;
                    n_state  = S_FLUSH;
                end
            end
            S_JUMP_WAIT: begin
                if (i_div_rsp.done) begin
                    n_start = stamp64 - BW'(i_div_rsp.remainder);
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (r_count > {1'b0, r_maxact}) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_out.kind  = tcp_pkg::KIND_FLUSH;
                        n_out.chunk_base = r_oldest[SB-1:0];
                        n_oldest    = r_newest;
                        n_count     = r_count - 1'b1;
                    end
                end else begin
                    if (r_count == '0) begin
                        n_oldest = r_start;
                        n_newest = r_start;
                        n_count  = 2'd1;
                    end else begin
                        n_newest = r_start;
                        n_count  = 2'd2;
                    end
                    n_base  = r_start;
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                n_off   = off_prod[tcp_pkg::OFF_W-1:0];
                n_state = S_SLOT_WAIT;
            end
            S_SLOT_WAIT: begin
                if (i_div_rsp.done) begin
                    n_res.kind         = tcp_pkg::KIND_PLACED;
                    n_res.chunk_base   = r_base[SB-1:0];
                    n_res.packet_slot  = i_div_rsp.quotient[tcp_pkg::SLOT_W-1:0];
                    n_res.byte_offset  = r_off;
                    n_res.final_result = 1'b1;
                    n_state            = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_count     <= '0;
            r_first     <= '0;
            r_oldest    <= '0;
            r_newest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_count     <= n_count;
            r_first     <= n_first;
            r_oldest    <= n_oldest;
            r_newest    <= n_newest;
            r_out_valid <= n_out_valid;
        end
        r_has    <= n_has;
        r_stamp  <= n_stamp;
        r_len    <= n_len;
        r_start  <= n_start;
        r_base   <= n_base;
        r_maxact <= n_maxact;
        r_off    <= n_off;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_before_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> r_count == '0) else $error("window open before first item");
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_started) |-> (r_count == 2'd1 || r_count == 2'd2))
        else $error("window size out of range between items");
    a_flush_not_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == tcp_pkg::KIND_FLUSH) |-> !r_out.final_result)
        else $error("flush item marked final");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |=> (r_state == S_FIRST_WAIT || r_state == S_MOD_WAIT ||
                             r_state == S_JUMP_WAIT || r_state == S_SLOT_WAIT))
        else $error("division issued without waiting for it");

endmodule

/* test/chunk_placement_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_placement_checker: predicts and checks timestamp chunk placements
// Watches the configuration port and both item channels of the placer. Each
// accepted descriptor is run through a local window model, and each output
// item is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module chunk_placement_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tcp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  tcp_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  tcp_pkg::t_out_item             i_out_data,
    output int                             o_pending,
    output int                             o_fail_count
);

    logic [tcp_pkg::SPP_W-1:0] pkt_samples;
    logic [tcp_pkg::SPC_W-1:0] chunk_size;
    logic [tcp_pkg::BPS_W-1:0] sample_width;

    logic        win_started;
    logic [63:0] win_origin;
    int          win_count;
    logic [63:0] win_oldest;
    logic [63:0] win_newest;

    tcp_pkg::t_out_item placements_due[$];
    int                 fails = 0;

    task automatic add_due(input tcp_pkg::t_kind kind, input logic [63:0] base,
                           input logic [63:0] slot, input logic [63:0] off,
                           input logic last);
        tcp_pkg::t_out_item r;
        r.kind         = kind;
        r.chunk_base   = base[tcp_pkg::STAMP_BITS-1:0];
        r.packet_slot  = slot[tcp_pkg::SLOT_W-1:0];
        r.byte_offset  = off[tcp_pkg::OFF_W-1:0];
        r.final_result = last;
        placements_due.insert(placements_due.size(), r);
    endtask

    task automatic predict_placement(input tcp_pkg::t_in_item pkt);
        logic [63:0] stamp;
        logic [63:0] spp;
        logic [63:0] spc;
        logic [63:0] pkt_bytes;
        logic [63:0] diff;
        logic [63:0] base;
        logic [63:0] start;
        logic [63:0] sidx;
        int          keep;
        stamp     = 64'(pkt.stamp);
        spp       = 64'(pkt_samples);
        pkt_bytes = (spp / 8) * 64'(sample_width);
        if (!pkt.has_stamp || pkt.payload_bytes == '0) begin
            add_due(tcp_pkg::KIND_INVALID, '0, '0, '0, 1'b1);
            return;
        end
        if (64'(pkt.payload_bytes) != pkt_bytes || spp == 0) begin
            add_due(tcp_pkg::KIND_WRONG_SIZE, '0, '0, '0, 1'b1);
            return;
        end
        spc = (chunk_size != '0) ? 64'(chunk_size) : spp;

        // first packet past the size checks opens the window, aligned or not
        if (!win_started) begin
            win_started = 1'b1;
            win_origin  = stamp / spc * spc;
            win_count   = 1;
            win_oldest  = win_origin;
            win_newest  = win_origin;
        end
        if (win_count == 0) begin
            win_count  = 1;
            win_newest = win_oldest;
        end

        diff = (stamp >= win_origin) ? stamp - win_origin : win_origin - stamp;
        if (diff % spp != 0) begin
            add_due(tcp_pkg::KIND_MISALIGNED, '0, '0, '0, 1'b1);
            return;
        end

        if (stamp >= win_oldest && stamp < win_oldest + spc) begin
            base = win_oldest;
        end else if (win_count >= 2 && stamp >= win_newest && stamp < win_newest + spc) begin
            base = win_newest;
        end else if (stamp < win_oldest) begin
            add_due(tcp_pkg::KIND_TOO_OLD, '0, '0, '0, 1'b1);
            return;
        end else begin
            start = win_newest + spc;
            keep  = 1;
            // more than one chunk ahead: drop the whole window and skip forward
            if (stamp >= start + spc) begin
                start = start + (stamp - start) / spc * spc;
                keep  = 0;
            end
            while (win_count > keep) begin
                add_due(tcp_pkg::KIND_FLUSH, win_oldest, '0, '0, 1'b0);
                win_oldest = win_newest;
                win_count--;
            end
            if (win_count == 0) begin
                win_oldest = start;
                win_newest = start;
                win_count  = 1;
            end else begin
                win_newest = start;
                win_count  = 2;
            end
            base = start;
        end

        sidx = stamp - base;
        add_due(tcp_pkg::KIND_PLACED, base, sidx / spp, (sidx / 8) * 64'(sample_width),
                1'b1);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        tcp_pkg::t_out_item want;
        if (!i_rst_n) begin
            pkt_samples   = tcp_pkg::SPP_RESET;
            chunk_size    = tcp_pkg::SPC_RESET;
            sample_width  = tcp_pkg::BPS_RESET;
            win_started   = 1'b0;
            win_origin    = '0;
            win_count     = 0;
            win_oldest    = '0;
            win_newest    = '0;
            placements_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tcp_pkg::CFG_SPP: begin
                        pkt_samples = i_cfg_data[tcp_pkg::SPP_W-1:0];
                    end
                    tcp_pkg::CFG_SPC: begin
                        chunk_size = i_cfg_data[tcp_pkg::SPC_W-1:0];
                    end
                    tcp_pkg::CFG_BPS: begin
                        sample_width = i_cfg_data[tcp_pkg::BPS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // retire the output before predicting, so a new item never
            // matches a result in the same cycle
            if (i_out_valid && !i_out_stall) begin
                if (placements_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected item, expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    want = placements_due[0];
                    placements_due.delete(0);
                    check_field("kind", 64'(want.kind), 64'(i_out_data.kind));
                    check_field("chunk_base", 64'(want.chunk_base),
                                64'(i_out_data.chunk_base));
                    check_field("packet_slot", 64'(want.packet_slot),
                                64'(i_out_data.packet_slot));
                    check_field("byte_offset", 64'(want.byte_offset),
                                64'(i_out_data.byte_offset));
                    check_field("final_result", 64'(want.final_result),
                                64'(i_out_data.final_result));
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_placement(i_in_data);
        end
        o_pending    <= placements_due.size();
        o_fail_count <= fails;
    end

endmodule

/* test/tb_timestamp_chunk_placer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamp_chunk_placer: testbench of the timestamp chunk placer
// Directed descriptors at reset settings, then random descriptor walks across
// several packet/chunk geometries and at the top of the stamp range, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_timestamp_chunk_placer;

    localparam logic [63:0] STAMP_MASK = 64'hFFFF_FFFF_FFFF;
    // first opened chunk: the misaligned directed packet lands in chunk 5
    localparam logic [63:0] ORIGIN     = 64'd5 * 64'd1048576;
    localparam logic [63:0] DFLT_SPP   = 64'd4096;
    localparam logic [63:0] DFLT_SPC   = 64'd1048576;
    localparam logic [63:0] DFLT_BYTES = 64'd5120;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [tcp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tcp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    tcp_pkg::t_in_item              in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    tcp_pkg::t_out_item             out_data;
    int                             pending;
    int                             fail_count;

    logic        quiet   = 1'b0;
    int          item_no = 0;
    logic [63:0] cur_spp = DFLT_SPP;
    logic [63:0] cur_spc = DFLT_SPC;
    logic [63:0] cur_bps = 64'd10;
    logic [63:0] cursor  = ORIGIN;

    timestamp_chunk_placer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    chunk_placement_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99, 0) < 25);
    end

    function automatic logic [63:0] random_stamp();
        return {$urandom, $urandom} & STAMP_MASK;
    endfunction

    task automatic send_item(input tcp_pkg::t_in_item it);
        if (!quiet) begin
            while ($urandom_range(99, 0) < 25) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        item_no++;
        quiet <= (item_no >= 150 && item_no < 230);
    endtask

    task automatic send_desc(input logic has, input logic [63:0] stamp,
                             input logic [63:0] len);
        tcp_pkg::t_in_item it;
        it.has_stamp     = has;
        it.stamp         = stamp[tcp_pkg::STAMP_BITS-1:0];
        it.payload_bytes = len[tcp_pkg::LEN_W-1:0];
        send_item(it);
    endtask

    // random descriptor: mostly well-formed steps of a walking timestamp,
    // the rest invalid, wrong size, misaligned or behind the window
    function automatic tcp_pkg::t_in_item next_descriptor();
        tcp_pkg::t_in_item it;
        logic [63:0] unit;
        logic [63:0] spc_eff;
        logic [63:0] cpk;
        logic [63:0] pkt_bytes;
        logic [63:0] stamp_v;
        logic [63:0] rnd_stamp;
        int          r;
        int          m;
        unit      = (cur_spp != 0) ? cur_spp : 64'd1;
        spc_eff   = (cur_spc != 0) ? cur_spc : unit;
        cpk       = spc_eff / unit;
        if (cpk == 0)
            cpk = 1;
        pkt_bytes = (cur_spp / 8) * cur_bps;
        it.has_stamp     = 1'b1;
        it.stamp         = cursor[tcp_pkg::STAMP_BITS-1:0];
        it.payload_bytes = pkt_bytes[tcp_pkg::LEN_W-1:0];
        r = $urandom_range(99, 0);
        if (r < 8) begin
            rnd_stamp    = random_stamp();
            it.has_stamp = ($urandom_range(1, 0) == 1);
            it.stamp     = rnd_stamp[tcp_pkg::STAMP_BITS-1:0];
            it.payload_bytes = it.has_stamp ? '0
                               : tcp_pkg::LEN_W'($urandom_range(20'hFFFFF, 0));
        end else if (r < 16) begin
            it.payload_bytes = tcp_pkg::LEN_W'($urandom_range(20'hFFFFF, 1));
        end else if (r < 24) begin
            if (unit > 1) begin
                stamp_v  = cursor + 64'($urandom_range(32'(unit - 1), 1));
                it.stamp = stamp_v[tcp_pkg::STAMP_BITS-1:0];
            end
        end else begin
            m = $urandom_range(99, 0);
            if (m < 60)
                cursor = cursor + 64'($urandom_range(3, 0)) * unit;
            else if (m >= 72 && m < 87)
                cursor = cursor + 64'($urandom_range(32'(2 * cpk), 1)) * unit;
            else if (m >= 87 && m < 95)
                cursor = cursor + 64'($urandom_range(6, 2)) * cpk * unit;
            else if (m >= 95 && m < 98)
                cursor = cursor + (({32'd0, $urandom} << 8) / unit) * unit;
            cursor  = cursor & STAMP_MASK;
            stamp_v = cursor;
            // backward probes leave the walk where it is
            if (m >= 60 && m < 72)
                stamp_v = cursor - 64'($urandom_range(32'(2 * cpk), 1)) * unit;
            else if (m >= 98)
                stamp_v = ORIGIN - 64'($urandom_range(32'(ORIGIN / unit), 1)) * unit;
            it.stamp = stamp_v[tcp_pkg::STAMP_BITS-1:0];
        end
        return it;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_item(next_descriptor());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic configure(input logic [63:0] spp, input logic [63:0] spc,
                             input logic [63:0] bps);
        logic [63:0] unit;
        logic [63:0] k;
        cfg_we    <= 1'b1;
        cfg_index <= tcp_pkg::CFG_SPP;
        cfg_data  <= spp[tcp_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= tcp_pkg::CFG_SPC;
        cfg_data  <= spc[tcp_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= tcp_pkg::CFG_BPS;
        cfg_data  <= bps[tcp_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_spp = spp;
        cur_spc = spc;
        cur_bps = bps;
        // re-seat the walk on the new packet grid just past where it was
        unit   = (spp != 0) ? spp : 64'd1;
        k      = (cursor >= ORIGIN) ? (cursor - ORIGIN) / unit : 64'd0;
        cursor = (ORIGIN + (k + 1) * unit) & STAMP_MASK;
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 256 packets of 4096 samples per chunk
        send_desc(1'b0, STAMP_MASK, DFLT_BYTES);
        send_desc(1'b1, 64'd0, 64'd0);
        send_desc(1'b1, ORIGIN, 64'hFFFFF);
        send_desc(1'b1, ORIGIN, DFLT_BYTES - 1);
        send_desc(1'b1, ORIGIN + 3, DFLT_BYTES);          // opens chunk, misaligned
        send_desc(1'b1, ORIGIN, DFLT_BYTES);
        send_desc(1'b1, ORIGIN + 255 * DFLT_SPP, DFLT_BYTES);
        send_desc(1'b1, ORIGIN + 256 * DFLT_SPP, DFLT_BYTES);  // second chunk
        send_desc(1'b1, ORIGIN + DFLT_SPP, DFLT_BYTES);
        send_desc(1'b1, ORIGIN + 512 * DFLT_SPP, DFLT_BYTES);  // one flush
        send_desc(1'b1, ORIGIN + 10 * DFLT_SPP, DFLT_BYTES);   // too old
        send_desc(1'b1, ORIGIN + 300 * DFLT_SPP, DFLT_BYTES);
        send_desc(1'b1, ORIGIN + 513 * DFLT_SPP, DFLT_BYTES);
        send_desc(1'b1, ORIGIN + 5 * DFLT_SPC + 7 * DFLT_SPP, DFLT_BYTES);  // skip ahead
        send_desc(1'b1, ORIGIN + 6 * DFLT_SPC, DFLT_BYTES);
        send_desc(1'b1, STAMP_MASK, DFLT_BYTES);
        send_desc(1'b1, 64'd0, DFLT_BYTES);
        cursor = ORIGIN + 6 * DFLT_SPC;
        run_random(80);

        drain();
        configure(64'd8, 64'd32, 64'd1);
        run_random(70);
        drain();
        configure(64'd8, 64'd8, 64'd16);
        run_random(50);
        drain();
        configure(64'd65536, 64'd67108864, 64'd16);
        run_random(50);
        drain();
        configure(64'd16, 64'd0, 64'd3);
        run_random(50);
        drain();
        configure(64'd24, 64'd100, 64'd7);
        run_random(60);
        drain();
        configure(64'h1FFFF, 64'h7FFFFFF, 64'd31);
        run_random(40);
        drain();
        configure(64'd4, 64'd8, 64'd5);        // packet of zero bytes
        run_random(20);
        drain();
        configure(64'd0, 64'd64, 64'd9);
        run_random(15);
        drain();
        configure(64'd32, 64'd128, 64'd0);
        run_random(15);
        drain();
        configure(64'd8, 64'd16, 64'd12);
        run_random(40);

        // top of the timestamp range, last since the window never moves back
        send_desc(1'b1, STAMP_MASK + 1 - 64'd8, 64'd12);
        send_desc(1'b1, STAMP_MASK + 1 - 64'd16, 64'd12);
        send_desc(1'b1, STAMP_MASK, 64'd12);
        send_desc(1'b0, STAMP_MASK, 64'hFFFFF);

        drain();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
